@@ hdl/lifo_pkg.sv @@
// Package for the LIFO stack with indexed access.
// Holds operation codes, status codes, widths and the cell control struct.
// No dependencies.
package lifo_pkg;

  localparam int DEFAULT_STACK_DEPTH = 64;

  localparam int DATA_W = 32;
  localparam int MODE_W = 3;
  localparam int POS_W  = 8;
  localparam int STAT_W = 2;

  localparam int S_TDATA_W = 48;
  localparam int M_TDATA_W = 40;

  localparam logic [MODE_W-1:0] MODE_PUSH    = 3'd0;
  localparam logic [MODE_W-1:0] MODE_POP     = 3'd1;
  localparam logic [MODE_W-1:0] MODE_DISPLAY = 3'd2;
  localparam logic [MODE_W-1:0] MODE_PEEP    = 3'd3;
  localparam logic [MODE_W-1:0] MODE_CHANGE  = 3'd4;

  localparam logic [STAT_W-1:0] STAT_OK     = 2'd0;
  localparam logic [STAT_W-1:0] STAT_EMPTY  = 2'd1;
  localparam logic [STAT_W-1:0] STAT_FULL   = 2'd2;
  localparam logic [STAT_W-1:0] STAT_BADPOS = 2'd3;

  typedef struct packed {
    logic push;
    logic pop;
    logic write;
  } lifo_ctrl_t;

endpackage

@@ hdl/lifo_cell.sv @@
// One storage cell of the stack chain; cell 0 is the top of the stack.
// Shifts toward the bottom on push and toward the top on pop, and is
// written or read in place when the select index names it. Uses lifo_pkg.
module lifo_cell
  import lifo_pkg::*;
#(
  parameter int IDX_W = 6,
  parameter int INDEX = 0
) (
  input  logic                     clk,
  input  lifo_ctrl_t               ctrl,
  input  logic [IDX_W-1:0]         sel,
  input  logic signed [DATA_W-1:0] wr_value,
  input  logic signed [DATA_W-1:0] from_above,
  input  logic signed [DATA_W-1:0] from_below,
  output logic signed [DATA_W-1:0] q,
  output logic signed [DATA_W-1:0] rd
);

  logic hit;

  assign hit = (sel == IDX_W'(INDEX));
  assign rd  = hit ? q : '0;

  always_ff @(posedge clk) begin
    if (ctrl.push) begin
      q <= from_above;
    end else if (ctrl.pop) begin
      q <= from_below;
    end else if (ctrl.write && hit) begin
      q <= wr_value;
    end
  end

endmodule

@@ hdl/lifo_stack_with_indexed_access.sv @@
// LIFO stack of signed 32-bit values held in a chain of STACK_DEPTH cells,
// with the top of the stack always in cell 0. Push, pop, peep and change take
// one input item and produce one result item: the item is accepted and its
// result is registered in the output register, so a steady stream runs at
// one item every cycle while m_tready stays high, and a stalled consumer
// holds off the input for as long as the result waits.
// Display produces one result per stored entry, top first, one per cycle while
// m_tready stays high, with tlast on the bottom entry (a single empty-status
// result if the stack is empty); no new item is accepted until the last entry
// has been loaded. Peep and change count positions from the top, 0 and 1 both
// naming the top entry. Mode codes 5 to 7 are taken and produce no result.
// Depends on lifo_pkg and lifo_cell.
module lifo_stack_with_indexed_access
  import lifo_pkg::*;
#(
  parameter int STACK_DEPTH = DEFAULT_STACK_DEPTH
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 s_tvalid,
  output logic                 s_tready,
  // mode [2:0], value [34:3], position [42:35], zero [47:43]
  input  logic [S_TDATA_W-1:0] s_tdata,
  output logic                 m_tvalid,
  input  logic                 m_tready,
  // status [1:0], data [33:2], zero [39:34]
  output logic [M_TDATA_W-1:0] m_tdata,
  output logic                 m_tlast
);

  localparam int IDX_W = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
  localparam int CNT_W = $clog2(STACK_DEPTH + 1);

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_DISP = 1'b1;

  logic                     state;
  logic [CNT_W-1:0]         count;
  logic [IDX_W-1:0]         disp_idx;

  logic [STAT_W-1:0]        out_status;
  logic signed [DATA_W-1:0] out_data;
  logic                     out_last;

  logic [MODE_W-1:0]        in_mode;
  logic signed [DATA_W-1:0] in_value;
  logic [POS_W-1:0]         in_pos;

  logic                     out_free;
  logic                     accept;
  logic                     is_empty;
  logic                     is_full;
  logic [POS_W-1:0]         from_top;
  logic                     pos_ok;
  logic [IDX_W-1:0]         sel;
  logic                     disp_last;
  lifo_ctrl_t               ctrl;
  logic signed [DATA_W-1:0] rd_data;

  logic signed [DATA_W-1:0] cell_q  [STACK_DEPTH];
  logic signed [DATA_W-1:0] cell_rd [STACK_DEPTH];

  assign in_mode  = s_tdata[MODE_W-1:0];
  assign in_value = s_tdata[MODE_W+DATA_W-1:MODE_W];
  assign in_pos   = s_tdata[MODE_W+DATA_W+POS_W-1:MODE_W+DATA_W];

  assign out_free = !m_tvalid || m_tready;
  assign s_tready = (state == ST_IDLE) && out_free;
  assign accept   = s_tvalid && s_tready;

  assign is_empty = (count == '0);
  assign is_full  = (count == CNT_W'(STACK_DEPTH));
  assign from_top = (in_pos <= POS_W'(1)) ? '0 : in_pos - POS_W'(1);
  assign pos_ok   = ({1'b0, from_top} < (POS_W + 1)'(count));
  assign sel      = (state == ST_DISP) ? disp_idx : from_top[IDX_W-1:0];
  assign disp_last = ((CNT_W'(disp_idx) + CNT_W'(1)) == count);

  always_comb begin
    ctrl.push  = accept && (in_mode == MODE_PUSH) && !is_full;
    ctrl.pop   = accept && (in_mode == MODE_POP) && !is_empty;
    ctrl.write = accept && (in_mode == MODE_CHANGE) && !is_empty && pos_ok;
  end

  always_comb begin
    rd_data = '0;
    for (int i = 0; i < STACK_DEPTH; i++) begin
      rd_data = rd_data | cell_rd[i];
    end
  end

  for (genvar g = 0; g < STACK_DEPTH; g++) begin : g_cell
    logic signed [DATA_W-1:0] above;
    logic signed [DATA_W-1:0] below;
    if (g == 0) begin : g_top
      assign above = in_value;
    end else begin : g_mid
      assign above = cell_q[g-1];
    end
    if (g == STACK_DEPTH - 1) begin : g_bot
      assign below = cell_q[g];
    end else begin : g_up
      assign below = cell_q[g+1];
    end
    lifo_cell #(
      .IDX_W (IDX_W),
      .INDEX (g)
    ) u_cell (
      .clk        (clk),
      .ctrl       (ctrl),
      .sel        (sel),
      .wr_value   (in_value),
      .from_above (above),
      .from_below (below),
      .q          (cell_q[g]),
      .rd         (cell_rd[g])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      count    <= '0;
      m_tvalid <= 1'b0;
    end else begin
      if (accept) begin
        case (in_mode)
          MODE_PUSH: begin
            m_tvalid <= 1'b1;
            if (!is_full) begin
              count <= count + CNT_W'(1);
            end
          end
          MODE_POP: begin
            m_tvalid <= 1'b1;
            if (!is_empty) begin
              count <= count - CNT_W'(1);
            end
          end
          MODE_DISPLAY: begin
            if (is_empty) begin
              m_tvalid <= 1'b1;
            end else begin
              m_tvalid <= 1'b0;
              state    <= ST_DISP;
            end
          end
          MODE_PEEP, MODE_CHANGE: begin
            m_tvalid <= 1'b1;
          end
          default: begin
            m_tvalid <= 1'b0;
          end
        endcase
      end else if (state == ST_DISP && out_free) begin
        m_tvalid <= 1'b1;
        if (disp_last) begin
          state <= ST_IDLE;
        end
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      disp_idx <= '0;
      out_last <= 1'b1;
      case (in_mode)
        MODE_PUSH: begin
          out_status <= is_full ? STAT_FULL : STAT_OK;
          out_data   <= is_full ? '0 : in_value;
        end
        MODE_POP: begin
          out_status <= is_empty ? STAT_EMPTY : STAT_OK;
          out_data   <= is_empty ? '0 : cell_q[0];
        end
        MODE_DISPLAY: begin
          out_status <= STAT_EMPTY;
          out_data   <= '0;
        end
        MODE_PEEP: begin
          if (is_empty) begin
            out_status <= STAT_EMPTY;
            out_data   <= '0;
          end else if (!pos_ok) begin
            out_status <= STAT_BADPOS;
            out_data   <= '0;
          end else begin
            out_status <= STAT_OK;
            out_data   <= rd_data;
          end
        end
        MODE_CHANGE: begin
          if (is_empty) begin
            out_status <= STAT_EMPTY;
            out_data   <= '0;
          end else if (!pos_ok) begin
            out_status <= STAT_BADPOS;
            out_data   <= '0;
          end else begin
            out_status <= STAT_OK;
            out_data   <= in_value;
          end
        end
        default: begin
        end
      endcase
    end else if (state == ST_DISP && out_free) begin
      out_status <= STAT_OK;
      out_data   <= rd_data;
      out_last   <= disp_last;
      disp_idx   <= disp_idx + IDX_W'(1);
    end
  end

  assign m_tdata = {(M_TDATA_W - STAT_W - DATA_W)'(0), out_data, out_status};
  assign m_tlast = out_last;

endmodule
